@@ rtl/u8dec_pkg.sv @@
// ----------------------------------------------------------------------------
// u8dec_pkg: shared types and constants of the UTF-8 to UCS-2 decoder
// Holds the result and packet formats that move from the front end through
// the queue to the output stage, and the decoder's fixed constants.
// ----------------------------------------------------------------------------
package u8dec_pkg;

   localparam logic [7:0]  MAX_UNITS     = 8'd255;
   localparam logic [15:0] REPLACE_CODE  = 16'hFFFD;

   localparam logic [7:0]  CONT_MASK     = 8'hC0;
   localparam logic [7:0]  CONT_MATCH    = 8'h80;
   localparam logic [7:0]  LEAD2_MASK    = 8'hE0;
   localparam logic [7:0]  LEAD2_MATCH   = 8'hC0;
   localparam logic [7:0]  LEAD3_MASK    = 8'hF0;
   localparam logic [7:0]  LEAD3_MATCH   = 8'hE0;
   localparam logic [7:0]  LEAD4_MASK    = 8'hF8;
   localparam logic [7:0]  LEAD4_MATCH   = 8'hF0;

   localparam logic [1:0]  SKIP_LEAD4    = 2'd3;

   localparam int          QUEUE_DEPTH   = 4;
   localparam int          QUEUE_AW      = $clog2(QUEUE_DEPTH);

   // One result word.
   typedef struct packed {
      logic [7:0]  total_units;
      logic        is_end;
      logic [15:0] code_unit;
   } result_type;

   // All results caused by one input byte (one or two).
   typedef struct packed {
      logic       has_second;
      result_type second;
      result_type first;
   } packet_type;

endpackage

@@ rtl/u8dec_front.sv @@
// ----------------------------------------------------------------------------
// u8dec_front: byte classifier and code assembler
// Takes one byte per cycle while the queue is not full, updates the decoding
// state and pushes a packet of one or two results into the queue when the byte produces any.
// ----------------------------------------------------------------------------
module u8dec_front
   import u8dec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_valid,
   input  logic [7:0]  name_byte,
   input  logic        queue_full,
   output logic        byte_ready,
   output logic        push_valid,
   output packet_type  push_packet
);

   logic [15:0] partial_code_ff, partial_code_in;
   logic [1:0]  bytes_expected_ff, bytes_expected_in;
   logic [1:0]  bytes_to_skip_ff, bytes_to_skip_in;
   logic [7:0]  units_emitted_ff, units_emitted_in;

   logic        take;
   logic        lead_emit;
   logic [15:0] lead_code;
   logic [15:0] lead_partial;
   logic [1:0]  lead_expected;
   logic [1:0]  lead_skip;
   logic [15:0] merged;
   logic [7:0]  units_plus1;

   assign byte_ready = !queue_full;
   assign take       = byte_valid && byte_ready;
   assign units_plus1 = units_emitted_ff + 8'd1;

   // Decode of the byte as the start of a new character.
   always_comb begin
      lead_emit     = 1'b0;
      lead_code     = {8'd0, name_byte};
      lead_partial  = 16'd0;
      lead_expected = 2'd0;
      lead_skip     = 2'd0;
      if (!name_byte[7]) begin
         lead_emit = 1'b1;
      end else if ((name_byte & LEAD2_MASK) == LEAD2_MATCH) begin
         lead_partial  = {5'd0, name_byte[4:0], 6'd0};
         lead_expected = 2'd1;
      end else if ((name_byte & LEAD3_MASK) == LEAD3_MATCH) begin
         lead_partial  = {name_byte[3:0], 12'd0};
         lead_expected = 2'd2;
      end else if ((name_byte & LEAD4_MASK) == LEAD4_MATCH) begin
         lead_emit = 1'b1;
         lead_code = REPLACE_CODE;
         lead_skip = SKIP_LEAD4;
      end
   end

   // Continuation payload: the first of two continuations lands six bits up.
   assign merged = (bytes_expected_ff == 2'd2) ?
                   (partial_code_ff | {4'd0, name_byte[5:0], 6'd0}) :
                   (partial_code_ff | {10'd0, name_byte[5:0]});

   always_comb begin
      partial_code_in   = partial_code_ff;
      bytes_expected_in = bytes_expected_ff;
      bytes_to_skip_in  = bytes_to_skip_ff;
      units_emitted_in  = units_emitted_ff;
      push_valid        = 1'b0;
      push_packet       = '0;

      if (take) begin
         if (name_byte == 8'd0) begin
            push_valid = 1'b1;
            if (bytes_expected_ff != 2'd0) begin
               push_packet.first.code_unit   = partial_code_ff;
               push_packet.has_second        = 1'b1;
               push_packet.second.is_end     = 1'b1;
               push_packet.second.total_units = units_plus1;
            end else begin
               push_packet.first.is_end      = 1'b1;
               push_packet.first.total_units = units_emitted_ff;
            end
            partial_code_in   = 16'd0;
            bytes_expected_in = 2'd0;
            bytes_to_skip_in  = 2'd0;
            units_emitted_in  = 8'd0;
         end else if (units_emitted_ff >= MAX_UNITS) begin
            // Limit reached: drop until the terminator.
         end else if (bytes_to_skip_ff != 2'd0) begin
            bytes_to_skip_in = bytes_to_skip_ff - 2'd1;
         end else if (bytes_expected_ff != 2'd0) begin
            if ((name_byte & CONT_MASK) == CONT_MATCH) begin
               bytes_expected_in = bytes_expected_ff - 2'd1;
               if (bytes_expected_ff == 2'd1) begin
                  push_valid                  = 1'b1;
                  push_packet.first.code_unit = merged;
                  partial_code_in             = 16'd0;
                  units_emitted_in            = units_plus1;
               end else begin
                  partial_code_in = merged;
               end
            end else begin
               // Missing continuation: flush the partial code, then treat
               // the byte as a new lead if the limit still allows.
               push_valid                  = 1'b1;
               push_packet.first.code_unit = partial_code_ff;
               partial_code_in             = 16'd0;
               bytes_expected_in           = 2'd0;
               units_emitted_in            = units_plus1;
               if (units_plus1 < MAX_UNITS) begin
                  partial_code_in   = lead_partial;
                  bytes_expected_in = lead_expected;
                  bytes_to_skip_in  = lead_skip;
                  if (lead_emit) begin
                     push_packet.has_second       = 1'b1;
                     push_packet.second.code_unit = lead_code;
                     units_emitted_in             = units_emitted_ff + 8'd2;
                  end
               end
            end
         end else begin
            partial_code_in   = lead_partial;
            bytes_expected_in = lead_expected;
            bytes_to_skip_in  = lead_skip;
            if (lead_emit) begin
               push_valid                  = 1'b1;
               push_packet.first.code_unit = lead_code;
               units_emitted_in            = units_plus1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_code_ff   <= 16'd0;
         bytes_expected_ff <= 2'd0;
         bytes_to_skip_ff  <= 2'd0;
         units_emitted_ff  <= 8'd0;
      end else begin
         partial_code_ff   <= partial_code_in;
         bytes_expected_ff <= bytes_expected_in;
         bytes_to_skip_ff  <= bytes_to_skip_in;
         units_emitted_ff  <= units_emitted_in;
      end
   end

endmodule

@@ rtl/u8dec_queue.sv @@
// ----------------------------------------------------------------------------
// u8dec_queue: short packet queue between front end and output stage
// A small first-in first-out buffer of result packets.
// ----------------------------------------------------------------------------
module u8dec_queue
   import u8dec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  packet_type push_packet,
   output logic       full,
   input  logic       pop,
   output logic       not_empty,
   output packet_type pop_packet
);

   packet_type               slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]        count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign not_empty  = (count_ff != '0);
   assign pop_packet = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_packet;
      end
   end

endmodule

@@ rtl/u8dec_back.sv @@
// ----------------------------------------------------------------------------
// u8dec_back: result output stage
// Takes packets from the queue and presents their results one word per
// cycle while out_ready allows, in a registered output stage.
// ----------------------------------------------------------------------------
module u8dec_back
   import u8dec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       not_empty,
   input  packet_type pop_packet,
   output logic       pop,
   output logic       out_valid,
   output result_type out_result,
   input  logic       out_ready
);

   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff, out_result_in;
   logic       second_pending_ff, second_pending_in;
   result_type second_ff, second_in;
   logic       slot_free;

   assign slot_free  = !out_valid_ff || out_ready;
   assign pop        = slot_free && !second_pending_ff && not_empty;
   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;

   always_comb begin
      out_valid_in      = out_valid_ff;
      out_result_in     = out_result_ff;
      second_pending_in = second_pending_ff;
      second_in         = second_ff;
      if (slot_free) begin
         if (second_pending_ff) begin
            out_valid_in      = 1'b1;
            out_result_in     = second_ff;
            second_pending_in = 1'b0;
         end else if (not_empty) begin
            out_valid_in      = 1'b1;
            out_result_in     = pop_packet.first;
            second_pending_in = pop_packet.has_second;
            second_in         = pop_packet.second;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff      <= 1'b0;
         second_pending_ff <= 1'b0;
      end else begin
         out_valid_ff      <= out_valid_in;
         second_pending_ff <= second_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      out_result_ff <= out_result_in;
      second_ff     <= second_in;
   end

endmodule

@@ rtl/utf8_to_ucs2_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder: streaming UTF-8 name to UCS-2 code unit decoder
// Path: a byte that produces a result is written into a queue slot, then
// moved into the output register (front end to queue, queue to output register).
// Throughput: one byte per cycle while the queue is not full; the output stage drains
// one word per cycle while rsp_tready is high, so a byte that yields two results takes two output words.
// Reset: synchronous, active high; clears decoding state, queue and output.
// ----------------------------------------------------------------------------
//
// The front end classifies each byte (ASCII, two- or three-byte lead,
// continuation, four-byte lead, invalid, terminator) and updates the code
// being assembled. Each byte that produces results pushes one packet of one
// or two result words into a four-entry queue. The back end pulls packets
// and hands their words out through a registered output stage, so the input
// keeps flowing while a result waits to be taken. The input stalls only
// when the queue is full.
//
// A zero byte flushes any partial code, then produces an end word that
// carries the number of code units emitted for the name, and the decoder
// returns to its reset state for the next name.
module utf8_to_ucs2_decoder
   import u8dec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input bytes.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] name_byte
   // Result words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] code_unit, [23:16] total_units, [31:24] zero
   output logic        rsp_tlast    // is_end: the end word after the terminator
);

   logic       queue_full;
   logic       push_valid;
   packet_type push_packet;
   logic       pop;
   logic       not_empty;
   packet_type pop_packet;
   result_type out_result;

   u8dec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .name_byte   (req_tdata),
      .queue_full  (queue_full),
      .byte_ready  (req_tready),
      .push_valid  (push_valid),
      .push_packet (push_packet)
   );

   u8dec_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_packet (push_packet),
      .full        (queue_full),
      .pop         (pop),
      .not_empty   (not_empty),
      .pop_packet  (pop_packet)
   );

   u8dec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .not_empty   (not_empty),
      .pop_packet  (pop_packet),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_result  (out_result),
      .out_ready   (rsp_tready)
   );

   // Pack the result word onto the stream bus.
   assign rsp_tdata = {8'd0, out_result.total_units, out_result.code_unit};
   assign rsp_tlast = out_result.is_end;

endmodule
